FILE: sv/cwq_pkg.sv
// ----------------------------------------------------------------------------
// cwq_pkg
// Shared types and codes for the compacting wait queue.
// ----------------------------------------------------------------------------
package cwq_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_LINE_LENGTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_SPACING = 2'd1;

  localparam logic OP_JOIN  = 1'b0;
  localparam logic OP_LEAVE = 1'b1;

  typedef enum logic [1:0] {
    KIND_JOIN  = 2'd0,
    KIND_LEAVE = 2'd1,
    KIND_MOVE  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_PRESENT  = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_MATCH,
    CMD_WRITE,
    CMD_DROP,
    CMD_SWAP,
    CMD_ROTATE
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t cmd;
    logic      phase;
  } cell_ctl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MATCH,
    S_PICK,
    S_APPLY,
    S_COMPACT,
    S_ACK,
    S_ROT
  } state_t;

endpackage

FILE: sv/cwq_cell.sv
// ----------------------------------------------------------------------------
// cwq_cell
// One slot of the line: holds an ID and a valid bit, is written or cleared when
// selected, compares against the request, swaps with a neighbor during
// compaction and shifts during rotation.
module cwq_cell #(
  parameter int ID_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  cwq_pkg::cell_ctl_t  ctl,
  input  logic [ID_BITS-1:0]  req_id,
  input  logic                sel,
  input  logic                vis,
  input  logic                tail,
  input  logic                odd,
  input  logic                left_valid,
  input  logic [ID_BITS-1:0]  left_id,
  input  logic                right_valid,
  input  logic [ID_BITS-1:0]  right_id,
  input  logic                head_valid,
  input  logic [ID_BITS-1:0]  head_id,
  output logic [ID_BITS-1:0]  id,
  output logic                valid,
  output logic                hit,
  output logic                emp,
  output logic                pair
);
  import cwq_pkg::*;

  logic               valid_next;
  logic [ID_BITS-1:0] id_next;

  assign pair = vis & ~tail & ~valid & right_valid;

  always_comb begin
    valid_next = valid;
    id_next    = id;
    case (ctl.cmd)
      CMD_WRITE: begin
        if (sel) begin
          valid_next = 1'b1;
          id_next    = req_id;
        end
      end
      CMD_DROP: begin
        if (sel) begin
          valid_next = 1'b0;
        end
      end
      CMD_SWAP: begin
        if (vis) begin
          if (odd == ctl.phase) begin
            if (pair) begin
              valid_next = right_valid;
              id_next    = right_id;
            end
          end else if (!left_valid && valid) begin
            valid_next = left_valid;
            id_next    = left_id;
          end
        end
      end
      CMD_ROTATE: begin
        if (vis) begin
          valid_next = tail ? head_valid : right_valid;
          id_next    = tail ? head_id : right_id;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      hit   <= 1'b0;
      emp   <= 1'b0;
    end else begin
      valid <= valid_next;
      if (ctl.cmd == CMD_MATCH) begin
        hit <= vis & valid & (id == req_id);
        emp <= vis & ~valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    id <= id_next;
  end

endmodule

FILE: sv/compacting_wait_queue.sv
// ----------------------------------------------------------------------------
// compacting_wait_queue
// Line of agent slots with join and leave-with-compaction requests.
// ----------------------------------------------------------------------------
// A join, or a leave whose agent is absent, passes after its beat is accepted
// through per-slot compare, find-first and apply, and is answered from the
// apply step once the output is free. A leave that finds its agent then
// compacts the line by neighbor swaps in the slot chain (one swap phase per
// cycle), answers once the output is free, and rotates the visible slots
// once through the head slot in L steps with L = min(line_length, DEPTH),
// one move notice per occupant, one per cycle unless the output stalls.
// Requests are taken one at a time; the next request is taken once the
// sequencer is back in idle, which for a leave means after the full
// rotation, even when its final notice went out earlier.
module compacting_wait_queue #(
  parameter int DEPTH   = 16,
  parameter int ID_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [cwq_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cwq_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              opcode,
  input  logic [15:0]                       agent_id,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        kind,
  output logic [1:0]                        status,
  output logic [15:0]                       agent_id_res,
  output logic [3:0]                        slot_index,
  output logic [19:0]                       position,
  output logic                              last
);
  import cwq_pkg::*;

  localparam int IDX_BITS = $clog2(DEPTH);
  localparam int LEN_W    = $clog2(DEPTH + 1);
  localparam int XW       = ID_BITS + 16;
  localparam int PW       = IDX_BITS + 20;
  localparam int SW       = IDX_BITS + 4;

  logic [4:0]          line_length;
  logic [15:0]         slot_spacing;
  logic [LEN_W-1:0]    len_eff;

  state_t              state, state_next;
  logic                req_op;
  logic [ID_BITS-1:0]  req_id;
  logic [DEPTH-1:0]    sel_hit, sel_emp;
  logic                any_hit, any_emp;
  logic                phase, phase_next;
  logic [LEN_W-1:0]    rot, rot_next;
  logic [IDX_BITS-1:0] w, w_next;
  logic                rot_last;
  logic [IDX_BITS-1:0] emp_idx;

  cell_ctl_t           ctl;
  logic [DEPTH-1:0]    sel;
  logic [ID_BITS-1:0]  cid [DEPTH];
  logic [DEPTH-1:0]    cvalid, chit, cemp, cpair;

  logic                out_free;
  logic                emit;
  kind_t               e_kind;
  status_t             e_status;
  logic [ID_BITS-1:0]  e_id;
  logic [IDX_BITS-1:0] e_idx;
  logic                e_last;

  logic [XW-1:0]       in_ext, res_ext;
  logic [PW-1:0]       prod;
  logic [SW-1:0]       idx_ext;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      line_length  <= 5'd16;
      slot_spacing <= 16'd100;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_LINE_LENGTH:  line_length  <= cfg_data[4:0];
        REG_SLOT_SPACING: slot_spacing <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (32'(line_length) > DEPTH) begin
      len_eff = LEN_W'(DEPTH);
    end else begin
      len_eff = LEN_W'(line_length);
    end
  end

  // slot chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic               lv, rv;
    logic [ID_BITS-1:0] lid, rid;
    if (i == 0) begin : g_first
      assign lv  = 1'b1;
      assign lid = '0;
    end else begin : g_mid
      assign lv  = cvalid[i-1];
      assign lid = cid[i-1];
    end
    if (i == DEPTH - 1) begin : g_end
      assign rv  = 1'b0;
      assign rid = '0;
    end else begin : g_inner
      assign rv  = cvalid[i+1];
      assign rid = cid[i+1];
    end
    cwq_cell #(
      .ID_BITS(ID_BITS)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .req_id     (req_id),
      .sel        (sel[i]),
      .vis        (LEN_W'(i) < len_eff),
      .tail       (LEN_W'(i + 1) == len_eff),
      .odd        (1'(i % 2)),
      .left_valid (lv),
      .left_id    (lid),
      .right_valid(rv),
      .right_id   (rid),
      .head_valid (cvalid[0]),
      .head_id    (cid[0]),
      .id         (cid[i]),
      .valid      (cvalid[i]),
      .hit        (chit[i]),
      .emp        (cemp[i]),
      .pair       (cpair[i])
    );
  end

  // request capture and find-first
  assign in_ext = XW'(agent_id);

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      req_op <= opcode;
      req_id <= in_ext[ID_BITS-1:0];
    end
    if (state == S_PICK) begin
      sel_hit <= chit & (~chit + DEPTH'(1));
      sel_emp <= cemp & (~cemp + DEPTH'(1));
      any_hit <= |chit;
      any_emp <= |cemp;
    end
  end

  always_comb begin
    emp_idx = '0;
    for (int k = 0; k < DEPTH; k++) begin
      if (sel_emp[k]) begin
        emp_idx = emp_idx | IDX_BITS'(k);
      end
    end
  end

  // sequencer
  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign rot_last = (rot + LEN_W'(1)) == len_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= 1'b0;
      rot   <= '0;
      w     <= '0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      rot   <= rot_next;
      w     <= w_next;
    end
  end

  always_comb begin
    state_next = state;
    phase_next = phase;
    rot_next   = rot;
    w_next     = w;
    ctl.cmd    = CMD_HOLD;
    ctl.phase  = phase;
    sel        = '0;
    emit       = 1'b0;
    e_kind     = KIND_JOIN;
    e_status   = ST_OK;
    e_id       = req_id;
    e_idx      = '0;
    e_last     = 1'b1;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_MATCH;
        end
      end
      S_MATCH: begin
        ctl.cmd    = CMD_MATCH;
        state_next = S_PICK;
      end
      S_PICK: begin
        state_next = S_APPLY;
      end
      S_APPLY: begin
        if (out_free) begin
          if (req_op == OP_JOIN) begin
            emit       = 1'b1;
            state_next = S_IDLE;
            if (!any_emp) begin
              e_status = ST_FULL;
            end else if (any_hit) begin
              e_status = ST_PRESENT;
            end else begin
              e_idx   = emp_idx;
              ctl.cmd = CMD_WRITE;
              sel     = sel_emp;
            end
          end else if (!any_hit) begin
            emit       = 1'b1;
            e_kind     = KIND_LEAVE;
            e_status   = ST_NOTFOUND;
            state_next = S_IDLE;
          end else begin
            ctl.cmd    = CMD_DROP;
            sel        = sel_hit;
            state_next = S_COMPACT;
          end
        end
      end
      S_COMPACT: begin
        if (|cpair) begin
          ctl.cmd    = CMD_SWAP;
          phase_next = ~phase;
        end else begin
          state_next = S_ACK;
        end
      end
      S_ACK: begin
        if (out_free) begin
          emit       = 1'b1;
          e_kind     = KIND_LEAVE;
          e_last     = !cvalid[0];
          rot_next   = '0;
          w_next     = '0;
          state_next = cvalid[0] ? S_ROT : S_IDLE;
        end
      end
      S_ROT: begin
        if (!cvalid[0] || out_free) begin
          ctl.cmd  = CMD_ROTATE;
          rot_next = rot + LEN_W'(1);
          if (rot_last) begin
            state_next = S_IDLE;
          end
          if (cvalid[0]) begin
            emit   = 1'b1;
            e_kind = KIND_MOVE;
            e_id   = cid[0];
            e_idx  = w;
            e_last = rot_last || !cvalid[1];
            w_next = w + IDX_BITS'(1);
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // output register
  assign prod    = PW'(e_idx) * PW'(slot_spacing);
  assign idx_ext = SW'(e_idx);
  assign res_ext = XW'(e_id);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      kind         <= e_kind;
      status       <= e_status;
      agent_id_res <= res_ext[15:0];
      slot_index   <= idx_ext[3:0];
      position     <= prod[19:0];
      last         <= e_last;
    end
  end

  // checks
  a_compact_done: assert property (@(posedge clk) disable iff (rst)
    state == S_ACK |-> !(|cpair))
    else $error("answer given with gaps left in the line");

  a_pick_onehot: assert property (@(posedge clk) disable iff (rst)
    state == S_APPLY |-> $onehot0(sel_hit) && $onehot0(sel_emp))
    else $error("slot selection not one-hot");

  a_count_kept: assert property (@(posedge clk) disable iff (rst)
    (state == S_COMPACT || state == S_ROT) && $past(state) == state
      |-> $countones(cvalid) == $past($countones(cvalid)))
    else $error("occupant count changed while compacting or rotating");

  a_beat_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(last))
    else $error("stalled result beat lost");

endmodule
